/* hw/rtl/clock_page_replacement_top_assert.svh */
// assertion macros for the clock page replacement block
`ifndef CLOCK_PAGE_REPLACEMENT_TOP_ASSERT_SVH
`define CLOCK_PAGE_REPLACEMENT_TOP_ASSERT_SVH

// condition that must hold at every clock edge out of reset
`define CPR_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// implication checked on the same edge
`define CPR_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/cpr_pkg.sv */
// shared types and constants for the clock page replacement block
`timescale 1ns / 1ps

package cpr_pkg;

	localparam int FRAMES  = 16;
	localparam int IDX_W   = 4;
	localparam int PAGE_W  = 8;
	localparam int CFG_W   = 5;
	localparam int FAULT_W = 32;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(FRAMES);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_SWEEP = 4'b0100,
		S_EVICT = 4'b1000
	} state_t;

endpackage

/* hw/rtl/cpr_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps

module cpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH < 2) ? 1 : $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/clock_page_replacement_top.sv */
// clock (second-chance) page replacement: sequencer, frame state and page ram
//
//   channel   | handshake          | beat contents
//   ----------+--------------------+-------------------------------------------------
//   reference | start / busy       | page, end_of_run
//   result    | done (one cycle)   | hit, frame_index, evicted_valid, evicted_page,
//             |                    | fault_count
//   config    | cfg_we             | frames_in_use
//
// a reference beat keeps busy high while the frames in use are scanned in order;
// a hit ends the scan early, at the frame that holds the page
// a replacement adds a sweep over the frames the hand visits (at most all frames in use
// plus one) and a read of the victim out of the page ram
// the single compare unit and the one read port of the page ram mean one frame at a time
// reset is asynchronous and clears valid and reference bits, hand, fault count and
// frames_in_use (to 16) at once; page ram contents are not cleared
// the result beat cannot be stalled: done is high for exactly one cycle
`timescale 1ns / 1ps
`include "clock_page_replacement_top_assert.svh"

module clock_page_replacement_top (
	input  logic                         clk,
	input  logic                         arst_n,
	// reference beat
	input  logic                         start,
	output logic                         busy,
	input  logic [cpr_pkg::PAGE_W-1:0]   page,
	input  logic                         end_of_run,
	// result beat
	output logic                         done,
	output logic                         hit,
	output logic [cpr_pkg::IDX_W-1:0]    frame_index,
	output logic                         evicted_valid,
	output logic [cpr_pkg::PAGE_W-1:0]   evicted_page,
	output logic [cpr_pkg::FAULT_W-1:0]  fault_count,
	// configuration
	input  logic                         cfg_we,
	input  logic [cpr_pkg::CFG_W-1:0]    frames_in_use
);

	import cpr_pkg::*;

	// sequencer and control
	state_t              state_q, state_d;
	logic [CFG_W-1:0]    cfg_q;
	logic [IDX_W-1:0]    n_last;          // highest frame index in use

	// latched reference
	logic [PAGE_W-1:0]   page_q;
	logic                eor_q;

	// frame state kept in flops
	logic [FRAMES-1:0]   valid_q;
	logic [FRAMES-1:0]   ref_q;
	logic [IDX_W-1:0]    hand_q;
	logic [FAULT_W-1:0]  faults_q;
	logic [FAULT_W-1:0]  fault_inc;

	// scan pipeline: issue address, then compare in the next cycle
	logic [IDX_W-1:0]    iss_q;
	logic                iss_end_q;
	logic                pend_q;
	logic [IDX_W-1:0]    pend_idx_q;
	logic                empty_seen_q;
	logic [IDX_W-1:0]    empty_idx_q;

	// page ram
	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	logic [IDX_W-1:0]    ram_raddr;
	logic [PAGE_W-1:0]   ram_rdata;

	// compare unit and finish decode
	logic                cmp_hit;
	logic                pend_empty;
	logic                empty_now;
	logic [IDX_W-1:0]    empty_idx_now;
	logic                scan_last;
	logic                fin;
	logic                fin_hit;
	logic [IDX_W-1:0]    fin_slot;
	logic                fin_evict;
	logic [PAGE_W-1:0]   fin_old;

	// result registers
	logic                done_q;
	logic                hit_q;
	logic [IDX_W-1:0]    frame_index_q;
	logic                evicted_valid_q;
	logic [PAGE_W-1:0]   evicted_page_q;
	logic [FAULT_W-1:0]  fault_count_q;

	// out-of-range frame counts clamp to 1 .. FRAMES
	always_comb begin
		priority if (cfg_q == '0) begin
			n_last = '0;
		end else if (cfg_q > CFG_W'(FRAMES)) begin
			n_last = IDX_W'(FRAMES - 1);
		end else begin
			n_last = IDX_W'(cfg_q - CFG_W'(1));
		end
	end

	// saturating fault increment
	assign fault_inc = (faults_q == '1) ? faults_q : faults_q + FAULT_W'(1);

	// shared compare on the page read back for the pending frame
	assign pend_empty    = pend_q && !valid_q[pend_idx_q];
	assign cmp_hit       = pend_q && valid_q[pend_idx_q] && (ram_rdata == page_q);
	assign empty_now     = empty_seen_q || pend_empty;
	assign empty_idx_now = empty_seen_q ? empty_idx_q : pend_idx_q;
	assign scan_last     = pend_q && (pend_idx_q == n_last);

	// ram reads the scan index while scanning, else the frame under the hand
	assign ram_raddr = (state_q == S_SCAN) ? iss_q : hand_q;

	always_comb begin
		state_d   = state_q;
		fin       = 1'b0;
		fin_hit   = 1'b0;
		fin_slot  = hand_q;
		fin_evict = 1'b0;
		fin_old   = '0;
		ram_we    = 1'b0;
		ram_waddr = hand_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (cmp_hit) begin
					// resident: only the reference bit changes
					fin      = 1'b1;
					fin_hit  = 1'b1;
					fin_slot = pend_idx_q;
				end else if (scan_last) begin
					if (empty_now) begin
						// fill lowest empty frame
						fin       = 1'b1;
						fin_slot  = empty_idx_now;
						ram_we    = 1'b1;
						ram_waddr = empty_idx_now;
					end else begin
						state_d = S_SWEEP;
					end
				end
			end
			S_SWEEP: begin
				// victim page is read this cycle, returned in evict
				if (!ref_q[hand_q]) begin
					state_d = S_EVICT;
				end
			end
			S_EVICT: begin
				fin       = 1'b1;
				fin_slot  = hand_q;
				fin_evict = 1'b1;
				fin_old   = ram_rdata;
				ram_we    = 1'b1;
				ram_waddr = hand_q;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (fin) begin
			state_d = S_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cfg_q        <= CFG_RESET;
			valid_q      <= '0;
			ref_q        <= '0;
			hand_q       <= '0;
			faults_q     <= '0;
			iss_q        <= '0;
			iss_end_q    <= 1'b0;
			pend_q       <= 1'b0;
			pend_idx_q   <= '0;
			empty_seen_q <= 1'b0;
			empty_idx_q  <= '0;
			done_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;

			if (cfg_we) begin
				cfg_q <= frames_in_use;
			end

			// accept a reference beat
			if (state_q == S_IDLE && start) begin
				iss_q        <= '0;
				iss_end_q    <= 1'b0;
				pend_q       <= 1'b0;
				empty_seen_q <= 1'b0;
			end

			if (state_q == S_SCAN) begin
				// issue side
				if (!iss_end_q) begin
					pend_q     <= 1'b1;
					pend_idx_q <= iss_q;
					if (iss_q == n_last) begin
						iss_end_q <= 1'b1;
					end else begin
						iss_q <= iss_q + IDX_W'(1);
					end
				end else begin
					pend_q <= 1'b0;
				end
				// remember the lowest empty frame
				if (pend_empty && !empty_seen_q) begin
					empty_seen_q <= 1'b1;
					empty_idx_q  <= pend_idx_q;
				end
				// hand outside the frames in use wraps before the sweep
				if (scan_last && !cmp_hit && !empty_now && hand_q > n_last) begin
					hand_q <= '0;
				end
			end

			// second chance: clear the bit and move on
			if (state_q == S_SWEEP && ref_q[hand_q]) begin
				ref_q[hand_q] <= 1'b0;
				hand_q        <= (hand_q == n_last) ? '0 : hand_q + IDX_W'(1);
			end

			if (fin) begin
				// end of run clears valid and reference bits, hand and fault count after this beat
				if (eor_q) begin
					valid_q  <= '0;
					ref_q    <= '0;
					hand_q   <= '0;
					faults_q <= '0;
				end else begin
					ref_q[fin_slot] <= 1'b1;
					if (!fin_hit) begin
						valid_q[fin_slot] <= 1'b1;
						faults_q          <= fault_inc;
					end
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			page_q <= page;
			eor_q  <= end_of_run;
		end
		if (fin) begin
			hit_q           <= fin_hit;
			frame_index_q   <= fin_slot;
			evicted_valid_q <= fin_evict;
			evicted_page_q  <= fin_old;
			fault_count_q   <= fin_hit ? faults_q : fault_inc;
		end
	end

	cpr_ram #(
		.WIDTH (PAGE_W),
		.DEPTH (FRAMES)
	) u_page_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (page_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign hit           = hit_q;
	assign frame_index   = frame_index_q;
	assign evicted_valid = evicted_valid_q;
	assign evicted_page  = evicted_page_q;
	assign fault_count   = fault_count_q;

	// a result beat always closes a busy stretch
	`CPR_ASSERT_IMPL(a_done_after_busy, done, $past(busy), "result beat without a prior busy cycle")
	// a replacement is never reported as a hit
	`CPR_ASSERT_IMPL(a_evict_not_hit, done && evicted_valid, !hit, "eviction flagged on a hit")
	// a fault always leaves a nonzero count
	`CPR_ASSERT_IMPL(a_fault_counted, done && !hit, fault_count != '0, "fault with zero count")
	// the reported frame lies within the frames in use
	`CPR_ASSERT_IMPL(a_slot_in_range, done, frame_index <= n_last, "frame index beyond frames in use")

endmodule

/* test/testbench.sv */
// self-checking testbench for the clock page replacement block
`timescale 1ns / 1ps

module testbench;
	import cpr_pkg::*;

	// one result beat per reference; fields as they leave the block
	typedef struct packed {
		logic                hit;
		logic [IDX_W-1:0]    frame_index;
		logic                evicted_valid;
		logic [PAGE_W-1:0]   evicted_page;
		logic [FAULT_W-1:0]  fault_count;
	} placement_t;

	// directed script: a reference beat or a frames_in_use write
	typedef enum logic {
		ROW_REF,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t           kind;
		logic [PAGE_W-1:0]   pg;
		logic                eor;
		logic [CFG_W-1:0]    cfg;
		logic                pinned;   // want below is typed in rather than predicted
		placement_t          want;
	} script_row_t;

	localparam placement_t FROM_MODEL = '0;
	localparam int WATCHDOG_LIMIT = 1000;
	// worst case reference: full sweep over 16 frames plus victim read
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_REFS = 850;
	localparam int IDLE_PCT = 19;

	// short directed part: reset state, extremes of page and frames_in_use,
	// end of run on a hit, single-frame sweep, duplicate residency
	localparam script_row_t SCRIPT [23] = '{
		// fresh after reset, 16 frames: fills from frame 0 upward
		'{ROW_REF, 8'd0,   1'b0, 5'd0,  1'b1, '{1'b0, 4'd0, 1'b0, 8'd0,   32'd1}},
		'{ROW_REF, 8'd255, 1'b0, 5'd0,  1'b1, '{1'b0, 4'd1, 1'b0, 8'd0,   32'd2}},
		'{ROW_REF, 8'd0,   1'b0, 5'd0,  1'b1, '{1'b1, 4'd0, 1'b0, 8'd0,   32'd2}},
		// hit with end of run: reported first, then everything cleared
		'{ROW_REF, 8'd255, 1'b1, 5'd0,  1'b1, '{1'b1, 4'd1, 1'b0, 8'd0,   32'd2}},
		'{ROW_REF, 8'd255, 1'b0, 5'd0,  1'b1, '{1'b0, 4'd0, 1'b0, 8'd0,   32'd1}},
		// zero frames acts as one: frame 0 full, sweep clears its bit and takes it
		'{ROW_CFG, 8'd0,   1'b0, 5'd0,  1'b0, FROM_MODEL},
		'{ROW_REF, 8'd7,   1'b0, 5'd0,  1'b1, '{1'b0, 4'd0, 1'b1, 8'd255, 32'd2}},
		'{ROW_REF, 8'd7,   1'b0, 5'd0,  1'b1, '{1'b1, 4'd0, 1'b0, 8'd0,   32'd2}},
		// above the frame count acts as 16: frame 1 is the lowest empty one
		'{ROW_CFG, 8'd0,   1'b0, 5'd31, 1'b0, FROM_MODEL},
		'{ROW_REF, 8'd8,   1'b0, 5'd0,  1'b1, '{1'b0, 4'd1, 1'b0, 8'd0,   32'd3}},
		// two frames, both referenced: full sweep round back to frame 0
		'{ROW_CFG, 8'd0,   1'b0, 5'd2,  1'b0, FROM_MODEL},
		'{ROW_REF, 8'd9,   1'b0, 5'd0,  1'b0, FROM_MODEL},
		'{ROW_REF, 8'd8,   1'b0, 5'd0,  1'b0, FROM_MODEL},
		'{ROW_REF, 8'd10,  1'b0, 5'd0,  1'b0, FROM_MODEL},
		// shrink to one frame so page 8 lands in frame 0 while frame 1 keeps it too
		'{ROW_CFG, 8'd0,   1'b0, 5'd1,  1'b0, FROM_MODEL},
		'{ROW_REF, 8'd8,   1'b0, 5'd0,  1'b0, FROM_MODEL},
		'{ROW_CFG, 8'd0,   1'b0, 5'd2,  1'b0, FROM_MODEL},
		'{ROW_REF, 8'd8,   1'b0, 5'd0,  1'b0, FROM_MODEL},
		// back to 16 frames: frames past the old count are still empty
		'{ROW_CFG, 8'd0,   1'b0, 5'd16, 1'b0, FROM_MODEL},
		'{ROW_REF, 8'hAA,  1'b0, 5'd0,  1'b0, FROM_MODEL},
		'{ROW_REF, 8'h55,  1'b0, 5'd0,  1'b0, FROM_MODEL},
		'{ROW_REF, 8'hAA,  1'b1, 5'd0,  1'b0, FROM_MODEL},
		'{ROW_REF, 8'h0F,  1'b0, 5'd0,  1'b0, FROM_MODEL}
	};

	// frames_in_use values for the first random phases, extremes first
	localparam logic [CFG_W-1:0] CFG_SWEEP [8] = '{5'd16, 5'd1, 5'd0, 5'd31,
		5'd2, 5'd17, 5'd8, 5'd15};

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [PAGE_W-1:0]     page;
	logic                  end_of_run;
	logic                  done;
	logic                  hit;
	logic [IDX_W-1:0]      frame_index;
	logic                  evicted_valid;
	logic [PAGE_W-1:0]     evicted_page;
	logic [FAULT_W-1:0]    fault_count;
	logic                  cfg_we;
	logic [CFG_W-1:0]      frames_in_use;

	// typed-in expectation travels with the reference beat
	logic                  pin_next;
	placement_t            pin_value;

	// shadow of the replacement state
	logic [PAGE_W-1:0]     held_page [FRAMES];
	bit                    resident [FRAMES];
	bit                    ref_bit [FRAMES];
	int                    hand_pos;
	logic [FAULT_W-1:0]    fault_total;
	logic [CFG_W-1:0]      cfg_frames;

	placement_t            predicted_placements [$];
	int                    refs_outstanding;
	int                    err_count;
	int                    stall_cycles;
	int                    idle_pct;

	clock_page_replacement_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.page          (page),
		.end_of_run    (end_of_run),
		.done          (done),
		.hit           (hit),
		.frame_index   (frame_index),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page),
		.fault_count   (fault_count),
		.cfg_we        (cfg_we),
		.frames_in_use (frames_in_use)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// second-chance placement of one page reference against the shadow state
	function automatic placement_t place_reference(input logic [PAGE_W-1:0] pg,
			input logic eor);
		placement_t res;
		int n;
		int slot;
		int steps;
		bit found;
		res = '0;
		slot = 0;
		found = 1'b0;
		// out-of-range frame counts clamp to 1..FRAMES
		n = (cfg_frames == 0) ? 1 : ((cfg_frames > FRAMES) ? FRAMES : int'(cfg_frames));
		// lowest-indexed resident copy wins
		for (int i = 0; i < n && !found; i++) begin
			if (resident[i] && held_page[i] == pg) begin
				slot = i;
				found = 1'b1;
			end
		end
		if (found) begin
			res.hit = 1'b1;
		end else begin
			for (int i = 0; i < n && !found; i++) begin
				if (!resident[i]) begin
					slot = i;
					found = 1'b1;
				end
			end
			if (!found) begin
				// hand left past the frames in use restarts at frame 0
				if (hand_pos >= n)
					hand_pos = 0;
				for (steps = 0; steps <= n && ref_bit[hand_pos]; steps++) begin
					ref_bit[hand_pos] = 1'b0;
					hand_pos = (hand_pos + 1) % n;
				end
				// hand stays on the victim
				slot = hand_pos;
				res.evicted_valid = 1'b1;
				res.evicted_page = held_page[slot];
			end
			held_page[slot] = pg;
			resident[slot] = 1'b1;
			if (fault_total != '1)
				fault_total++;
		end
		ref_bit[slot] = 1'b1;
		res.frame_index = slot[IDX_W-1:0];
		res.fault_count = fault_total;
		if (eor) begin
			resident = '{default: 1'b0};
			ref_bit = '{default: 1'b0};
			hand_pos = 0;
			fault_total = '0;
		end
		return res;
	endfunction

	task automatic flag_field(input string what, input logic [FAULT_W-1:0] want,
			input logic [FAULT_W-1:0] got);
		if (got !== want) begin
			err_count++;
			if (err_count <= 10)
				$display("%0t: %s mismatch, expected %0h got %0h", $time, what, want, got);
		end
	endtask

	// one reference beat: random gap, then hold start until the block takes it
	task automatic drive_ref(input logic [PAGE_W-1:0] pg, input logic eor,
			input logic pinned, input placement_t want);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		page <= pg;
		end_of_run <= eor;
		pin_next <= pinned;
		pin_value <= want;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
	endtask

	// frames_in_use only changes with the block idle and every result back
	task automatic write_frames(input logic [CFG_W-1:0] value);
		start <= 1'b0;
		@(posedge clk);
		wait (refs_outstanding == 0 && busy == 1'b0);
		@(posedge clk);
		cfg_we <= 1'b1;
		frames_in_use <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// monitor: config writes, result check, reference capture, watchdog
	always @(posedge clk) begin
		placement_t placed;
		if (arst_n) begin
			if (cfg_we)
				cfg_frames = frames_in_use;
			// results leave before new references land, so pop comes first
			if (done) begin
				if (predicted_placements.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("%0t: result beat with nothing outstanding", $time);
				end else begin
					placed = predicted_placements.pop_front();
					refs_outstanding--;
					flag_field("hit", FAULT_W'(placed.hit), FAULT_W'(hit));
					flag_field("frame_index", FAULT_W'(placed.frame_index),
						FAULT_W'(frame_index));
					flag_field("evicted_valid", FAULT_W'(placed.evicted_valid),
						FAULT_W'(evicted_valid));
					flag_field("evicted_page", FAULT_W'(placed.evicted_page),
						FAULT_W'(evicted_page));
					flag_field("fault_count", placed.fault_count, fault_count);
				end
			end
			if (start && !busy) begin
				placed = place_reference(page, end_of_run);
				predicted_placements.push_back(pin_next ? pin_value : placed);
				refs_outstanding++;
			end
			// cycles with no beat in either direction
			if ((start && !busy) || done)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles == WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		logic [PAGE_W-1:0] ws [34];
		logic [PAGE_W-1:0] pg;
		int phase;
		int sent;
		int count;
		int n;
		int ws_size;
		// everything known from time zero; shadow starts in its reset state
		arst_n = 1'b0;
		start = 1'b0;
		page = '0;
		end_of_run = 1'b0;
		cfg_we = 1'b0;
		frames_in_use = CFG_RESET;
		pin_next = 1'b0;
		pin_value = '0;
		held_page = '{default: '0};
		resident = '{default: 1'b0};
		ref_bit = '{default: 1'b0};
		hand_pos = 0;
		fault_total = '0;
		cfg_frames = CFG_RESET;
		refs_outstanding = 0;
		err_count = 0;
		stall_cycles = 0;
		idle_pct = IDLE_PCT;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed script
		foreach (SCRIPT[i]) begin
			if (SCRIPT[i].kind == ROW_CFG)
				write_frames(SCRIPT[i].cfg);
			else
				drive_ref(SCRIPT[i].pg, SCRIPT[i].eor, SCRIPT[i].pinned, SCRIPT[i].want);
		end

		// random phases: each picks a frame count and a working set a bit larger
		// than the frames, so hits, fills and sweeps all keep happening
		sent = 0;
		phase = 0;
		while (sent < RANDOM_REFS) begin
			write_frames(phase < 8 ? CFG_SWEEP[phase] : CFG_W'($urandom_range(0, 31)));
			n = (cfg_frames == 0) ? 1 : ((cfg_frames > FRAMES) ? FRAMES : int'(cfg_frames));
			ws_size = n + $urandom_range(1, n + 2);
			for (int i = 0; i < ws_size; i++)
				ws[i] = PAGE_W'($urandom_range(0, 255));
			// one long phase with the sender never pausing
			idle_pct = (phase == 3) ? 0 : IDLE_PCT;
			count = (phase == 3) ? 200 : $urandom_range(30, 90);
			for (int k = 0; k < count; k++) begin
				// mostly the working set, some stray pages
				if ($urandom_range(99) < 85)
					pg = ws[$urandom_range(0, ws_size - 1)];
				else
					pg = PAGE_W'($urandom_range(0, 255));
				drive_ref(pg, $urandom_range(99) < 2, 1'b0, FROM_MODEL);
				sent++;
			end
			phase++;
		end

		// drain: every result back, then a sweep's worth of quiet cycles
		start <= 1'b0;
		@(posedge clk);
		wait (refs_outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		err_count += predicted_placements.size();
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
